FILE: rtl/svm_pkg.sv
// Shared types, opcodes, status codes and constants of the stack machine executor.
package svm_pkg;

  localparam int MEM_WORDS = 4096;
  localparam int IDX_W = $clog2(MEM_WORDS);
  localparam logic [16:0] TOP = 17'(MEM_WORDS * 8);

  typedef enum logic [5:0] {
    OP_IMM  = 6'd0,  OP_LEA  = 6'd1,  OP_LC   = 6'd2,  OP_LI   = 6'd3,
    OP_SC   = 6'd4,  OP_SI   = 6'd5,  OP_PUSH = 6'd6,  OP_ADD  = 6'd7,
    OP_SUB  = 6'd8,  OP_MUL  = 6'd9,  OP_DIV  = 6'd10, OP_MOD  = 6'd11,
    OP_OR   = 6'd12, OP_XOR  = 6'd13, OP_AND  = 6'd14, OP_SHL  = 6'd15,
    OP_SHR  = 6'd16, OP_IQ   = 6'd17, OP_NE   = 6'd18, OP_LT   = 6'd19,
    OP_GT   = 6'd20, OP_GE   = 6'd21, OP_EQ   = 6'd22, OP_LE   = 6'd23,
    OP_JMP  = 6'd24, OP_JZ   = 6'd25, OP_JNZ  = 6'd26, OP_CALL = 6'd27,
    OP_NVAR = 6'd28, OP_DARG = 6'd29, OP_RET  = 6'd30, OP_OPEN = 6'd31,
    OP_CLOS = 6'd32, OP_READ = 6'd33, OP_PRTF = 6'd34, OP_MALC = 6'd35,
    OP_FREE = 6'd36, OP_MEST = 6'd37, OP_MCMP = 6'd38, OP_EXIT = 6'd39,
    OP_MSET = 6'd40
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EXIT    = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_FAULT   = 3'd4,
    ST_NATIVE  = 3'd5,
    ST_HALTED  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    MDU_MUL = 2'd0,
    MDU_DIV = 2'd1,
    MDU_MOD = 2'd2
  } mdu_op_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_RD0,
    FSM_RD1,
    FSM_CALC,
    FSM_MDU,
    FSM_WB
  } fsm_t;

  typedef struct packed {
    logic [5:0]         func;
    logic signed [63:0] imm;
    logic [31:0]        instr_addr;
  } in_t;

  typedef struct packed {
    logic signed [63:0] acc;
    logic [31:0]        next_pc;
    logic [15:0]        stack_ptr;
    logic [15:0]        frame_ptr;
    logic [2:0]         status;
    logic signed [63:0] exit_value;
  } out_t;

  typedef struct packed {
    logic load;
    logic rd0;
    logic rd1;
    logic mdu_start;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_mdu;
    logic mdu_done;
  } sts_t;

endpackage

FILE: rtl/svm_mdu.sv
// Iterative multiply and signed divide unit, one bit per cycle.
module svm_mdu (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  svm_pkg::mdu_op_t     op,
  input  logic [63:0]          x,
  input  logic [63:0]          a,
  output logic                 done,
  output logic [63:0]          result
);
  import svm_pkg::*;

  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] div_r, div_nxt;
  logic        nx_r, nx_nxt;
  logic        na_r, na_nxt;
  mdu_op_t     op_r, op_nxt;
  logic [64:0] rem_sh;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    nx_nxt   = nx_r;
    na_nxt   = na_r;
    op_nxt   = op_r;
    rem_sh   = {rem_r[63:0], quo_r[63]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'd0;
      op_nxt   = op;
      nx_nxt   = x[63];
      na_nxt   = a[63];
      if (op == MDU_MUL) begin
        // quo holds the shifting multiplier, div the shifting multiplicand.
        quo_nxt = a;
        div_nxt = x;
        rem_nxt = '0;
      end else begin
        quo_nxt = x[63] ? (64'd0 - x) : x;
        div_nxt = a[63] ? (64'd0 - a) : a;
        rem_nxt = '0;
      end
    end else if (busy_r) begin
      if (op_r == MDU_MUL) begin
        if (quo_r[0]) rem_nxt = {1'b0, rem_r[63:0] + div_r};
        quo_nxt = {1'b0, quo_r[63:1]};
        div_nxt = {div_r[62:0], 1'b0};
      end else begin
        if (rem_sh >= {1'b0, div_r}) begin
          rem_nxt = rem_sh - {1'b0, div_r};
          quo_nxt = {quo_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[62:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
      op_r   <= MDU_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    nx_r  <= nx_nxt;
    na_r  <= na_nxt;
  end

  always_comb begin
    case (op_r)
      MDU_MUL: result = rem_r[63:0];
      MDU_DIV: result = (nx_r != na_r) ? (64'd0 - quo_r) : quo_r;
      default: result = nx_r ? (64'd0 - rem_r[63:0]) : rem_r[63:0];
    endcase
  end

  assign done = done_r;

endmodule

FILE: rtl/svm_dp.sv
// Datapath: machine registers, word memory, execute logic and result register.
module svm_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  svm_pkg::in_t  in_data,
  input  svm_pkg::cmd_t cmd,
  output svm_pkg::sts_t sts,
  output svm_pkg::out_t out_data
);
  import svm_pkg::*;

  logic [63:0] mem [MEM_WORDS];
  logic [63:0] rd_data_r;

  logic [63:0] acc_r;
  logic [15:0] sp_r, bp_r;
  logic        halted_r;
  logic [5:0]  func_r;
  logic [63:0] imm_r;
  logic [31:0] pc_r;
  logic [63:0] x_r;
  out_t        out_r;

  logic [IDX_W-1:0] rd_idx;
  logic             rd_en;
  logic [IDX_W-1:0] wr_idx;
  logic [63:0]      wr_data;
  logic             wr_en;

  logic             mdu_done;
  logic [63:0]      mdu_res;
  mdu_op_t          mdu_op;

  logic        sp_ok, bp_ok, push_ok, is_pop;
  logic [15:0] spm8, spp8;
  logic [16:0] mv_n, mv_d;
  logic [63:0] y;
  logic [63:0] a_new, exitv, t, byte_w, mask;
  logic [7:0]  bt;
  logic [5:0]  sh;
  logic [15:0] sp_new, bp_new;
  logic [31:0] next;
  status_t     st;
  out_t        res;

  function automatic logic [16:0] move_ptr(input logic [15:0] p, input logic [63:0] v,
                                           input logic down);
    logic        neg;
    logic [63:0] mag;
    logic [17:0] delta;
    logic [17:0] sum;
    logic        ok;
    logic [15:0] r;
    neg   = v[63];
    mag   = neg ? (64'd0 - v) : v;
    delta = {mag[14:0], 3'b000};
    ok    = (mag <= 64'(MEM_WORDS));
    sum   = {2'b00, p} + delta;
    if (neg == down) begin
      if (sum > {1'b0, TOP}) ok = 1'b0;
      r = sum[15:0];
    end else begin
      if (delta > {2'b00, p}) ok = 1'b0;
      r = p - delta[15:0];
    end
    return {ok, r};
  endfunction

  assign sp_ok   = (sp_r[2:0] == 3'd0) && ({1'b0, sp_r} < TOP);
  assign bp_ok   = (bp_r[2:0] == 3'd0) && (({1'b0, bp_r} + 17'd16) <= TOP);
  assign push_ok = (sp_r >= 16'd8);
  assign spm8    = sp_r - 16'd8;
  assign spp8    = sp_r + 16'd8;
  assign is_pop  = (func_r >= OP_ADD) && (func_r <= OP_LE) && (func_r != OP_IQ);
  assign mv_n    = move_ptr(spm8, imm_r, 1'b1);
  assign mv_d    = move_ptr(sp_r, imm_r, 1'b0);
  assign y       = rd_data_r;

  // Read addresses: first a pointer, second the word read or bp+8 on RET.
  always_comb begin
    rd_en  = cmd.rd0 || cmd.rd1;
    rd_idx = sp_r[IDX_W+2:3];
    if (cmd.rd1) begin
      if (func_r == OP_RET) rd_idx = bp_r[IDX_W+2:3] + IDX_W'(1);
      else rd_idx = rd_data_r[IDX_W+2:3];
    end else begin
      case (func_r)
        OP_LC, OP_LI: rd_idx = acc_r[IDX_W+2:3];
        OP_RET:       rd_idx = bp_r[IDX_W+2:3];
        default:      rd_idx = sp_r[IDX_W+2:3];
      endcase
    end
  end

  always_comb begin
    case (func_r)
      OP_MUL:  mdu_op = MDU_MUL;
      OP_DIV:  mdu_op = MDU_DIV;
      default: mdu_op = MDU_MOD;
    endcase
  end

  assign sts.need_mdu = !halted_r && sp_ok &&
                        ((func_r == OP_MUL) ||
                         (((func_r == OP_DIV) || (func_r == OP_MOD)) && (acc_r != 64'd0)));
  assign sts.mdu_done = mdu_done;

  svm_mdu u_mdu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mdu_start),
    .op     (mdu_op),
    .x      (x_r),
    .a      (acc_r),
    .done   (mdu_done),
    .result (mdu_res)
  );

  always_comb begin
    a_new   = acc_r;
    sp_new  = sp_r;
    bp_new  = bp_r;
    next    = pc_r + 32'd1;
    st      = ST_OK;
    exitv   = '0;
    wr_en   = 1'b0;
    wr_idx  = sp_r[IDX_W+2:3];
    wr_data = acc_r;
    t       = x_r;
    sh      = {t[2:0], 3'b000};
    mask    = 64'hFF << sh;
    byte_w  = (y & ~mask) | ({56'd0, acc_r[7:0]} << sh);
    bt      = 8'(x_r >> {acc_r[2:0], 3'b000});
    if (halted_r) begin
      st   = ST_HALTED;
      next = pc_r;
    end else if (is_pop) begin
      if (!sp_ok) st = ST_FAULT;
      else begin
        sp_new = spp8;
        case (func_r)
          OP_ADD: a_new = x_r + acc_r;
          OP_SUB: a_new = x_r - acc_r;
          OP_MUL: a_new = mdu_res;
          OP_DIV, OP_MOD: begin
            if (acc_r == 64'd0) st = ST_DIVZERO;
            else a_new = mdu_res;
          end
          OP_OR:  a_new = x_r | acc_r;
          OP_XOR: a_new = x_r ^ acc_r;
          OP_AND: a_new = x_r & acc_r;
          OP_SHL: a_new = (acc_r[63:6] != '0) ? 64'd0 : (x_r << acc_r[5:0]);
          OP_SHR: a_new = (acc_r[63:6] != '0) ? {64{x_r[63]}}
                                              : 64'($signed(x_r) >>> acc_r[5:0]);
          OP_NE:  a_new = {63'd0, x_r != acc_r};
          OP_LT:  a_new = {63'd0, $signed(x_r) < $signed(acc_r)};
          OP_GT:  a_new = {63'd0, $signed(acc_r) < $signed(x_r)};
          OP_GE:  a_new = {63'd0, !($signed(x_r) < $signed(acc_r))};
          OP_EQ:  a_new = {63'd0, x_r == acc_r};
          default: a_new = {63'd0, !($signed(acc_r) < $signed(x_r))};
        endcase
      end
    end else begin
      unique case (func_r)
        OP_IMM: begin
          a_new = imm_r;
          next  = pc_r + 32'd2;
        end
        OP_LEA: begin
          a_new = {48'd0, bp_r} + {imm_r[60:0], 3'b000};
          next  = pc_r + 32'd2;
        end
        OP_LC: begin
          if (acc_r >= 64'(TOP)) st = ST_FAULT;
          else a_new = {{56{bt[7]}}, bt};
        end
        OP_LI: begin
          if ((acc_r[2:0] != 3'd0) || (acc_r >= 64'(TOP))) st = ST_FAULT;
          else a_new = x_r;
        end
        OP_SC: begin
          if (!sp_ok || (t >= 64'(TOP))) st = ST_FAULT;
          else begin
            wr_en   = 1'b1;
            wr_idx  = t[IDX_W+2:3];
            wr_data = byte_w;
            sp_new  = spp8;
          end
        end
        OP_SI: begin
          if (!sp_ok || (t[2:0] != 3'd0) || (t >= 64'(TOP))) st = ST_FAULT;
          else begin
            wr_en   = 1'b1;
            wr_idx  = t[IDX_W+2:3];
            wr_data = acc_r;
            sp_new  = spp8;
          end
        end
        OP_PUSH: begin
          if (!push_ok) st = ST_FAULT;
          else begin
            wr_en   = 1'b1;
            wr_idx  = spm8[IDX_W+2:3];
            wr_data = acc_r;
            sp_new  = spm8;
          end
        end
        OP_JMP: next = imm_r[31:0];
        OP_JZ:  next = (acc_r == 64'd0) ? imm_r[31:0] : pc_r + 32'd2;
        OP_JNZ: next = (acc_r != 64'd0) ? imm_r[31:0] : pc_r + 32'd2;
        OP_CALL: begin
          if (!push_ok) st = ST_FAULT;
          else begin
            wr_en   = 1'b1;
            wr_idx  = spm8[IDX_W+2:3];
            wr_data = {32'd0, pc_r + 32'd2};
            sp_new  = spm8;
            next    = imm_r[31:0];
          end
        end
        OP_NVAR: begin
          if (!push_ok || !mv_n[16]) st = ST_FAULT;
          else begin
            wr_en   = 1'b1;
            wr_idx  = spm8[IDX_W+2:3];
            wr_data = {48'd0, bp_r};
            bp_new  = spm8;
            sp_new  = mv_n[15:0];
            next    = pc_r + 32'd2;
          end
        end
        OP_DARG: begin
          if (!mv_d[16]) st = ST_FAULT;
          else begin
            sp_new = mv_d[15:0];
            next   = pc_r + 32'd2;
          end
        end
        OP_RET: begin
          if (!bp_ok || (t[2:0] != 3'd0) || (t > 64'(TOP))) st = ST_FAULT;
          else begin
            next   = y[31:0];
            sp_new = bp_r + 16'd16;
            bp_new = t[15:0];
          end
        end
        OP_OPEN, OP_CLOS, OP_READ, OP_PRTF, OP_MALC, OP_FREE, OP_MCMP, OP_MSET:
          st = ST_NATIVE;
        OP_EXIT: begin
          if (!sp_ok) st = ST_FAULT;
          else begin
            exitv = x_r;
            st    = ST_EXIT;
          end
        end
        default: st = ST_UNKNOWN;
      endcase
    end
  end

  always_comb begin
    res.acc        = acc_r;
    res.stack_ptr  = sp_r;
    res.frame_ptr  = bp_r;
    res.next_pc    = next;
    res.status     = st;
    res.exit_value = exitv;
    if (st == ST_OK) begin
      res.acc       = a_new;
      res.stack_ptr = sp_new;
      res.frame_ptr = bp_new;
    end else if ((st == ST_EXIT) || (st == ST_UNKNOWN) || (st == ST_DIVZERO) ||
                 (st == ST_FAULT)) begin
      res.next_pc = pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_idx];
    if (cmd.commit && wr_en && (st == ST_OK)) mem[wr_idx] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      sp_r     <= TOP[15:0];
      bp_r     <= TOP[15:0];
      halted_r <= 1'b0;
    end else if (cmd.commit) begin
      acc_r <= res.acc;
      sp_r  <= res.stack_ptr;
      bp_r  <= res.frame_ptr;
      if ((st == ST_EXIT) || (st == ST_UNKNOWN) || (st == ST_DIVZERO) || (st == ST_FAULT))
        halted_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_data.func;
      imm_r  <= in_data.imm;
      pc_r   <= in_data.instr_addr;
    end
    if (cmd.rd1) x_r <= rd_data_r;
    if (cmd.commit) out_r <= res;
  end

  assign out_data = out_r;

endmodule

FILE: rtl/svm_ctrl.sv
// Controller: sequences the phases of one instruction and owns both handshakes.
module svm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  svm_pkg::sts_t sts,
  output svm_pkg::cmd_t cmd
);
  import svm_pkg::*;

  fsm_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = (state_r == FSM_IDLE);
    unique case (state_r)
      FSM_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = FSM_RD0;
        end
      end
      FSM_RD0: begin
        cmd.rd0   = 1'b1;
        state_nxt = FSM_RD1;
      end
      FSM_RD1: begin
        cmd.rd1   = 1'b1;
        state_nxt = FSM_CALC;
      end
      FSM_CALC: begin
        if (sts.need_mdu) begin
          cmd.mdu_start = 1'b1;
          state_nxt     = FSM_MDU;
        end else begin
          state_nxt = FSM_WB;
        end
      end
      FSM_MDU: begin
        if (sts.mdu_done) state_nxt = FSM_WB;
      end
      FSM_WB: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/stack_vm_instruction_executor_top.sv
// Top level of the stack machine instruction executor: controller plus datapath.
// Each item goes through load, two reads of the word memory, a calculation step, a
// bit-serial multiply/divide pass for MUL, DIV and MOD (not on a fault, a halt or a
// zero divisor) and a write-back that waits for the previous result to be taken. A
// new item is accepted only after the write-back of the last one.
// Reset is synchronous: accumulator zero, both pointers at the memory top, not halted.
module stack_vm_instruction_executor_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  svm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output svm_pkg::out_t out_data
);
  import svm_pkg::*;

  // Command and status groups between the sequencer and the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller walks each item through load, first read, second read,
  // an optional multiply/divide pass and a write-back that loads the result
  // register. A finished result waits in that register while the next item
  // is taken in.
  svm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the machine state, the word memory and the result
  // register. Faulting instructions leave the state untouched and set halted.
  svm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

FILE: tb/tb_stack_vm_instruction_executor_top.sv
// Self-checking testbench of the stack machine instruction executor.
`timescale 1ns / 100ps

module tb_stack_vm_instruction_executor_top;
  import svm_pkg::*;

  localparam int unsigned MEM_TOP = MEM_WORDS * 8;
  localparam int IDLE_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  stack_vm_instruction_executor_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Our own copy of the machine state, advanced once per item sent.
  logic [63:0] vm_acc;
  int unsigned vm_sp, vm_bp;
  logic [63:0] vm_mem [MEM_WORDS];
  bit vm_written [MEM_WORDS];
  bit vm_halted;
  logic [31:0] cur_pc;

  out_t expected_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;

  // Moves a pointer by imm words (negated when going down); fails on leaving 0..top.
  function automatic bit move_words(input int unsigned p, input logic [63:0] imm,
                                    input bit down, output int unsigned res);
    bit neg;
    logic [63:0] mag;
    int unsigned delta;
    neg = imm[63];
    mag = neg ? -imm : imm;
    res = p;
    if (mag > MEM_WORDS) return 0;
    delta = mag[31:0] * 8;
    if (neg == down) begin
      if (p + delta > MEM_TOP) return 0;
      res = p + delta;
    end else begin
      if (delta > p) return 0;
      res = p - delta;
    end
    return 1;
  endfunction

  function automatic bit word_aligned(input logic [63:0] addr);
    return addr[2:0] == 3'd0 && addr < MEM_TOP;
  endfunction

  // Executes one instruction against the model state. Returns 1 when it would read
  // a word never written; the state is only updated when commit is set.
  function automatic bit execute_instr(input in_t it, input bit commit,
                                       output out_t res, output bit halts);
    logic [63:0] a, x, t, ux, ua, ev, wd;
    int unsigned sp, bp, np, widx, sh;
    logic [31:0] nxt;
    status_t st;
    bit unread, do_wr;
    a = vm_acc; x = '0; t = '0; ev = '0; wd = '0;
    sp = vm_sp; bp = vm_bp; np = 0; widx = 0;
    nxt = it.instr_addr + 32'd1;
    st = ST_OK; unread = 0; do_wr = 0;
    if (vm_halted) begin
      st = ST_HALTED;
      nxt = it.instr_addr;
    end else if (it.func >= OP_ADD && it.func <= OP_LE && it.func != OP_IQ) begin
      if (!word_aligned(sp)) st = ST_FAULT;
      else begin
        unread = !vm_written[sp >> 3];
        x = vm_mem[sp >> 3];
        sp += 8;
        case (it.func)
          OP_ADD: a = x + a;
          OP_SUB: a = x - a;
          OP_MUL: a = x * a;
          OP_DIV, OP_MOD: begin
            if (a == 0) st = ST_DIVZERO;
            else begin
              ux = x[63] ? -x : x;
              ua = a[63] ? -a : a;
              if (it.func == OP_DIV) a = (x[63] != a[63]) ? -(ux / ua) : ux / ua;
              else a = x[63] ? -(ux % ua) : ux % ua;
            end
          end
          OP_OR:  a = x | a;
          OP_XOR: a = x ^ a;
          OP_AND: a = x & a;
          OP_SHL: a = (a >= 64) ? '0 : x << a[5:0];
          OP_SHR: a = (a >= 64) ? {64{x[63]}} : 64'($signed(x) >>> a[5:0]);
          OP_NE:  a = 64'(x != a);
          OP_LT:  a = 64'($signed(x) < $signed(a));
          OP_GT:  a = 64'($signed(a) < $signed(x));
          OP_GE:  a = 64'(!($signed(x) < $signed(a)));
          OP_EQ:  a = 64'(x == a);
          default: a = 64'(!($signed(a) < $signed(x)));
        endcase
      end
    end else begin
      case (it.func)
        OP_IMM: begin a = it.imm; nxt = it.instr_addr + 32'd2; end
        OP_LEA: begin a = 64'(bp) + it.imm * 8; nxt = it.instr_addr + 32'd2; end
        OP_LC: begin
          if (a >= MEM_TOP) st = ST_FAULT;
          else begin
            unread = !vm_written[a >> 3];
            t = (vm_mem[a >> 3] >> (a[2:0] * 8)) & 64'hFF;
            a = {{56{t[7]}}, t[7:0]};
          end
        end
        OP_LI: begin
          if (!word_aligned(a)) st = ST_FAULT;
          else begin
            unread = !vm_written[a >> 3];
            a = vm_mem[a >> 3];
          end
        end
        OP_SC, OP_SI: begin
          if (!word_aligned(sp)) st = ST_FAULT;
          else begin
            unread = !vm_written[sp >> 3];
            t = vm_mem[sp >> 3];
            if (it.func == OP_SC) begin
              if (t >= MEM_TOP) st = ST_FAULT;
              else begin
                widx = t >> 3;
                sh = t[2:0] * 8;
                unread |= !vm_written[widx];
                wd = (vm_mem[widx] & ~(64'hFF << sh)) | ((a & 64'hFF) << sh);
                do_wr = 1;
              end
            end else if (!word_aligned(t)) st = ST_FAULT;
            else begin
              widx = t >> 3; wd = a; do_wr = 1;
            end
            sp += 8;
          end
        end
        OP_PUSH: begin
          if (sp < 8) st = ST_FAULT;
          else begin sp -= 8; widx = sp >> 3; wd = a; do_wr = 1; end
        end
        OP_JMP: nxt = it.imm[31:0];
        OP_JZ:  nxt = (a == 0) ? it.imm[31:0] : it.instr_addr + 32'd2;
        OP_JNZ: nxt = (a != 0) ? it.imm[31:0] : it.instr_addr + 32'd2;
        OP_CALL: begin
          if (sp < 8) st = ST_FAULT;
          else begin
            sp -= 8; widx = sp >> 3; wd = {32'd0, it.instr_addr + 32'd2}; do_wr = 1;
            nxt = it.imm[31:0];
          end
        end
        OP_NVAR: begin
          if (sp < 8 || !move_words(sp - 8, it.imm, 1, np)) st = ST_FAULT;
          else begin
            sp -= 8; widx = sp >> 3; wd = 64'(bp); do_wr = 1;
            bp = sp; sp = np; nxt = it.instr_addr + 32'd2;
          end
        end
        OP_DARG: begin
          if (!move_words(sp, it.imm, 0, np)) st = ST_FAULT;
          else begin sp = np; nxt = it.instr_addr + 32'd2; end
        end
        OP_RET: begin
          if (!word_aligned(bp) || bp + 16 > MEM_TOP) st = ST_FAULT;
          else begin
            unread = !vm_written[bp >> 3];
            t = vm_mem[bp >> 3];
            if (t[2:0] != 0 || t > MEM_TOP) st = ST_FAULT;
            else begin
              unread |= !vm_written[(bp >> 3) + 1];
              nxt = vm_mem[(bp >> 3) + 1][31:0];
              sp = bp + 16;
              bp = t[31:0];
            end
          end
        end
        OP_OPEN, OP_CLOS, OP_READ, OP_PRTF, OP_MALC, OP_FREE, OP_MCMP, OP_MSET:
          st = ST_NATIVE;
        OP_EXIT: begin
          if (!word_aligned(sp)) st = ST_FAULT;
          else begin
            unread = !vm_written[sp >> 3];
            ev = vm_mem[sp >> 3];
            st = ST_EXIT;
          end
        end
        default: st = ST_UNKNOWN;
      endcase
    end
    halts = st inside {ST_EXIT, ST_UNKNOWN, ST_DIVZERO, ST_FAULT};
    if (st != ST_OK) begin
      a = vm_acc; sp = vm_sp; bp = vm_bp;
      if (halts) nxt = it.instr_addr;
    end
    if (commit) begin
      if (halts) vm_halted = 1;
      if (st == ST_OK) begin
        vm_acc = a; vm_sp = sp; vm_bp = bp;
        if (do_wr) begin vm_mem[widx] = wd; vm_written[widx] = 1; end
      end
    end
    res.acc = a;
    res.next_pc = nxt;
    res.stack_ptr = sp[15:0];
    res.frame_ptr = bp[15:0];
    res.status = st;
    res.exit_value = ev;
    return unread;
  endfunction

  // Sends one instruction. One that would read an unwritten word, or halt the
  // machine where that is not wanted, is replaced by a load of a random immediate.
  task automatic send_instr(input logic [5:0] func, input logic [63:0] imm,
                            input bit allow_halt = 0);
    in_t it;
    out_t res;
    bit unread, halts;
    it.func = func;
    it.imm = imm;
    it.instr_addr = ($urandom_range(19) == 0) ? 32'($urandom) : cur_pc;
    unread = execute_instr(it, 0, res, halts);
    if (unread || (halts && !allow_halt)) begin
      it.func = OP_IMM;
      it.imm = {$urandom, $urandom};
    end
    void'(execute_instr(it, 1, res, halts));
    expected_results.push_back(res);
    cur_pc = res.next_pc;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return 64'(signed'($urandom_range(16)) - 8);
      3: return 64'($urandom_range(70));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Pushes x, then applies op with the accumulator holding a.
  task automatic binop(input op_t op, input logic [63:0] x, input logic [63:0] a);
    send_instr(OP_IMM, x);
    send_instr(OP_PUSH, '0);
    send_instr(OP_IMM, a);
    send_instr(op, '0);
  endtask

  // A call with k arguments, a frame of locals, a store and load through a local,
  // a byte access, the return and the clean-up of the arguments.
  task automatic call_frame(input int k, input int locals, input logic [63:0] val);
    repeat (k) send_instr(OP_PUSH, '0);
    send_instr(OP_CALL, 64'($urandom));
    send_instr(OP_NVAR, 64'(locals));
    send_instr(OP_LEA, -64'sd1);
    send_instr(OP_PUSH, '0);
    send_instr(OP_IMM, val);
    send_instr($urandom_range(1) ? OP_SI : OP_SC, '0);
    send_instr(OP_LEA, -64'(signed'($urandom_range(locals, 1))));
    send_instr(OP_LI, '0);
    send_instr(OP_LEA, 64'(signed'($urandom_range(15))) - 64'sd8);
    send_instr(OP_LC, '0);
    send_instr(OP_RET, '0);
    send_instr(OP_DARG, 64'(k));
  endtask

  task automatic test_arithmetic();
    binop(OP_DIV, 64'h8000_0000_0000_0000, -64'sd1);
    binop(OP_MOD, -64'sd7, 64'sd3);
    binop(OP_SHR, 64'h8000_0000_0000_0000, -64'sd1);
    binop(OP_SHL, 64'h7FFF_FFFF_FFFF_FFFF, 64'd63);
    binop(OP_LT, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    binop(OP_MUL, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_frames();
    call_frame(2, 3, 64'h8000_0000_0000_00FF);
  endtask

  task automatic test_jumps_and_native();
    send_instr(OP_JZ, 64'hFFFF_FFFF_FFFF_FFFF);
    send_instr(OP_JNZ, 64'd1234);
    send_instr(OP_JMP, 64'h1_0000_0010);
    send_instr(OP_MSET, '0);
    send_instr(OP_PRTF, '0);
  endtask

  // Random traffic: mostly well-formed sequences with random content, some noise.
  task automatic test_random(input int n_items);
    op_t ops [17] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_OR, OP_XOR, OP_AND,
                      OP_SHL, OP_SHR, OP_NE, OP_LT, OP_GT, OP_GE, OP_EQ, OP_LE, OP_ADD};
    op_t natives [8] = '{OP_OPEN, OP_CLOS, OP_READ, OP_PRTF, OP_MALC, OP_FREE,
                         OP_MCMP, OP_MSET};
    int sent;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          binop(ops[$urandom_range(16)], rand_value(), rand_value());
          sent += 4;
        end
        4, 5: begin
          call_frame($urandom_range(3), $urandom_range(4, 1), rand_value());
          sent += 14;
        end
        6: begin
          send_instr(OP_LEA, -64'(signed'($urandom_range(4))));
          send_instr(OP_LI, '0);
          send_instr(natives[$urandom_range(7)], rand_value());
          sent += 3;
        end
        default: begin
          send_instr(6'($urandom_range(OP_MSET)), rand_value());
          sent += 1;
        end
      endcase
    end
  endtask

  // Only one halt is possible per run, so the kind of halt is picked at random.
  task automatic test_halt();
    case ($urandom_range(3))
      0: begin
        send_instr(OP_PUSH, '0);
        send_instr(OP_IMM, '0);
        send_instr($urandom_range(1) ? OP_DIV : OP_MOD, '0, 1);
      end
      1: send_instr(($urandom_range(2) == 0) ? 6'(OP_IQ) :
                    ($urandom_range(1) ? 6'(OP_MEST) : 6'($urandom_range(63, 41))),
                    rand_value(), 1);
      2: begin
        send_instr(OP_IMM, 64'($urandom_range(MEM_TOP + 64)));
        send_instr(OP_LI, '0, 1);
        send_instr(OP_IMM, 64'(MEM_TOP) + 64'($urandom_range(8)));
        send_instr(OP_LC, '0, 1);
      end
      default: begin
        send_instr(OP_IMM, rand_value());
        send_instr(OP_PUSH, '0);
        send_instr(OP_EXIT, '0, 1);
      end
    endcase
    // Make sure the machine is halted even if the pick above did not get there.
    send_instr(6'd63, '0, 1);
    repeat (4) send_instr(6'($urandom_range(63)), rand_value(), 1);
  endtask

  // The receiver stalls at random; the checker compares each accepted result.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item: %p", out_data);
      end else begin
        out_t exp_res;
        exp_res = expected_results.pop_front();
        if (out_data.acc !== exp_res.acc || out_data.next_pc !== exp_res.next_pc ||
            out_data.stack_ptr !== exp_res.stack_ptr ||
            out_data.frame_ptr !== exp_res.frame_ptr ||
            out_data.status !== exp_res.status ||
            out_data.exit_value !== exp_res.exit_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %p, got %p", exp_res, out_data);
        end
      end
    end
  end

  // The watchdog counts cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    vm_acc = '0;
    vm_sp = MEM_TOP;
    vm_bp = MEM_TOP;
    vm_halted = 0;
    cur_pc = '0;
    foreach (vm_written[i]) vm_written[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_arithmetic();
    test_frames();
    test_jumps_and_native();
    sender_idle_pct = 0;  recv_stall_pct = 0;  test_random(200);
    sender_idle_pct = 60; recv_stall_pct = 0;  test_random(200);
    sender_idle_pct = 0;  recv_stall_pct = 60; test_random(200);
    sender_idle_pct = 13; recv_stall_pct = 13; test_random(200);
    test_halt();

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/svm_pkg.sv
rtl/svm_mdu.sv
rtl/svm_dp.sv
rtl/svm_ctrl.sv
rtl/stack_vm_instruction_executor_top.sv
tb/tb_stack_vm_instruction_executor_top.sv
